// ===== sv/pfci_pkg.sv =====
package pfci_pkg;

  // Default array address width (2**19 bytes)
  localparam int unsigned ADDR_BITS_DEFAULT = 19;

  // Fixed field widths
  localparam int unsigned BUS_ADDR_W = 19;
  localparam int unsigned DATA_W     = 8;

  // Bus access kinds
  typedef enum logic [1:0] {
    MODE_READ  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_PEEK  = 2'd2,
    MODE_LOAD  = 2'd3
  } mode_t;

  // Command sequence states
  typedef enum logic [3:0] {
    CMD_READ         = 4'd0,
    CMD_UNLOCK1      = 4'd1,
    CMD_UNLOCK2      = 4'd2,
    CMD_AUTOSELECT   = 4'd3,
    CMD_PROGRAM      = 4'd4,
    CMD_PROGRAMMING  = 4'd5,
    CMD_ERASE_U1     = 4'd6,
    CMD_ERASE_U2     = 4'd7,
    CMD_ERASE_SEL    = 4'd8,
    CMD_CHIP_ERASE   = 4'd9,
    CMD_SECTOR_ERASE = 4'd10
  } cmd_state_t;

  // Controller states
  typedef enum logic {
    CS_IDLE = 1'b0,
    CS_EXEC = 1'b1
  } ctrl_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;  // latch the beat and start the array read
    logic exec;    // commit the access and load the result register
  } ctrl_cmd_t;

  // Command bytes
  localparam logic [7:0] BYTE_UNLOCK1    = 8'haa;
  localparam logic [7:0] BYTE_UNLOCK2    = 8'h55;
  localparam logic [7:0] BYTE_AUTOSELECT = 8'h90;
  localparam logic [7:0] BYTE_PROGRAM    = 8'ha0;
  localparam logic [7:0] BYTE_ERASE      = 8'h80;
  localparam logic [7:0] BYTE_CHIP_ERASE = 8'h10;
  localparam logic [7:0] BYTE_SECT_ERASE = 8'h30;
  localparam logic [7:0] BYTE_RESET      = 8'hf0;

  // Magic addresses for the two layouts
  localparam logic [14:0] MAGIC_FIRST_WIDE   = 15'h5555;
  localparam logic [14:0] MAGIC_SECOND_WIDE  = 15'h2aaa;
  localparam logic [10:0] MAGIC_FIRST_NARROW  = 11'h555;
  localparam logic [10:0] MAGIC_SECOND_NARROW = 11'h2aa;

  // Autoselect ID bytes
  localparam logic [7:0] ID_ADDR_MFR   = 8'h00;
  localparam logic [7:0] ID_ADDR_DEV   = 8'h01;
  localparam logic [7:0] ID_ADDR_PROT  = 8'h02;
  localparam logic [7:0] ID_MFR        = 8'h01;
  localparam logic [7:0] ID_DEV        = 8'ha4;
  localparam logic [7:0] ID_PROT       = 8'h00;

  // One bus write through the command sequencer
  function automatic cmd_state_t cmd_next(cmd_state_t s, logic first, logic second,
                                          logic [7:0] b);
    cmd_state_t n;
    n = s;
    unique case (s)
      CMD_READ: begin
        if (first && b == BYTE_UNLOCK1) n = CMD_UNLOCK1;
      end
      CMD_UNLOCK1: begin
        n = (second && b == BYTE_UNLOCK2) ? CMD_UNLOCK2 : CMD_READ;
      end
      CMD_UNLOCK2: begin
        if (!first)                     n = CMD_READ;
        else if (b == BYTE_AUTOSELECT)  n = CMD_AUTOSELECT;
        else if (b == BYTE_PROGRAM)     n = CMD_PROGRAM;
        else if (b == BYTE_ERASE)       n = CMD_ERASE_U1;
        else                            n = CMD_READ;
      end
      CMD_PROGRAM: begin
        n = CMD_PROGRAMMING;
      end
      CMD_ERASE_U1: begin
        n = (first && b == BYTE_UNLOCK1) ? CMD_ERASE_U2 : CMD_READ;
      end
      CMD_ERASE_U2: begin
        n = (second && b == BYTE_UNLOCK2) ? CMD_ERASE_SEL : CMD_READ;
      end
      CMD_ERASE_SEL: begin
        if (first && b == BYTE_CHIP_ERASE) n = CMD_CHIP_ERASE;
        else if (b == BYTE_SECT_ERASE)     n = CMD_SECTOR_ERASE;
      end
      CMD_AUTOSELECT: begin
        if (b == BYTE_RESET) n = CMD_READ;
      end
      default: begin
        n = s;
      end
    endcase
    return n;
  endfunction

endpackage

// ===== sv/pfci_ram.sv =====
module pfci_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // Registered read port, holds when idle
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

// ===== sv/pfci_ctrl.sv =====
module pfci_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output pfci_pkg::ctrl_cmd_t cmd
);

  pfci_pkg::ctrl_state_t state, state_next;
  logic                  result_free;

  // Result register can take a new beat
  assign result_free = !out_valid || !out_stall;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      pfci_pkg::CS_IDLE: begin
        if (in_valid) state_next = pfci_pkg::CS_EXEC;
      end
      pfci_pkg::CS_EXEC: begin
        if (result_free) state_next = pfci_pkg::CS_IDLE;
      end
      default: begin
        state_next = pfci_pkg::CS_IDLE;
      end
    endcase
  end

  // Outputs; hold off the input while in reset
  always_comb begin
    in_stall   = rst || (state != pfci_pkg::CS_IDLE);
    cmd.accept = !rst && (state == pfci_pkg::CS_IDLE) && in_valid;
    cmd.exec   = (state == pfci_pkg::CS_EXEC) && result_free;
  end

  // Hold state and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pfci_pkg::CS_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.exec)       out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

endmodule

// ===== sv/pfci_dp.sv =====
module pfci_dp #(
  parameter int unsigned ADDR_BITS = pfci_pkg::ADDR_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pfci_pkg::ctrl_cmd_t                 cmd,
  input  logic                                cfg_write_enable,
  input  logic                                cfg_write_data,
  input  logic [1:0]                          mode,
  input  logic [pfci_pkg::BUS_ADDR_W-1:0]     address,
  input  logic [pfci_pkg::DATA_W-1:0]         write_data,
  input  logic                                read_modify_write,
  output logic [pfci_pkg::DATA_W-1:0]         read_data,
  output logic [3:0]                          command_state
);

  localparam int unsigned DEPTH = 2 ** ADDR_BITS;

  // Configuration and sequencer state
  logic                        address_layout;
  pfci_pkg::cmd_state_t        seq_state;
  logic [pfci_pkg::DATA_W-1:0] prev_read;

  // Latched beat
  pfci_pkg::mode_t                 item_mode;
  logic [pfci_pkg::BUS_ADDR_W-1:0] item_addr;
  logic [pfci_pkg::DATA_W-1:0]     item_data;
  logic                            item_rmw;

  // Array port
  logic                        ram_we;
  logic [ADDR_BITS-1:0]        ram_waddr;
  logic [pfci_pkg::DATA_W-1:0] ram_wdata;
  logic [ADDR_BITS-1:0]        ram_raddr;
  logic [pfci_pkg::DATA_W-1:0] ram_rdata;

  // Access evaluation
  logic                        at_first, at_second;
  pfci_pkg::cmd_state_t        step_state, write_state, seq_state_next;
  logic                        prog_early, prog_late;
  logic [pfci_pkg::DATA_W-1:0] prog_byte;
  logic [pfci_pkg::DATA_W-1:0] rd_value, prev_read_next;
  logic                        id_hit;
  logic [pfci_pkg::DATA_W-1:0] id_value;

  assign ram_raddr = ADDR_BITS'(address);
  assign ram_waddr = ADDR_BITS'(item_addr);

  pfci_ram #(
    .WIDTH (pfci_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_array (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.accept),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Match the magic addresses under the selected layout
  always_comb begin
    if (address_layout) begin
      at_first  = (item_addr[10:0] == pfci_pkg::MAGIC_FIRST_NARROW);
      at_second = (item_addr[10:0] == pfci_pkg::MAGIC_SECOND_NARROW);
    end else begin
      at_first  = (item_addr[14:0] == pfci_pkg::MAGIC_FIRST_WIDE);
      at_second = (item_addr[14:0] == pfci_pkg::MAGIC_SECOND_WIDE);
    end
  end

  // Run the write through the sequencer: last read byte first on RMW, then the bus byte
  always_comb begin
    step_state  = item_rmw ? pfci_pkg::cmd_next(seq_state, at_first, at_second, prev_read)
                           : seq_state;
    write_state = pfci_pkg::cmd_next(step_state, at_first, at_second, item_data);
    prog_early  = item_rmw && (seq_state == pfci_pkg::CMD_PROGRAM);
    prog_late   = (step_state == pfci_pkg::CMD_PROGRAM);
    prog_byte   = prog_early ? prev_read : item_data;
  end

  // Autoselect ID lookup
  always_comb begin
    id_hit   = 1'b1;
    id_value = pfci_pkg::ID_PROT;
    unique case (item_addr[7:0])
      pfci_pkg::ID_ADDR_MFR:  id_value = pfci_pkg::ID_MFR;
      pfci_pkg::ID_ADDR_DEV:  id_value = pfci_pkg::ID_DEV;
      pfci_pkg::ID_ADDR_PROT: id_value = pfci_pkg::ID_PROT;
      default:                id_hit   = 1'b0;
    endcase
  end

  // Commit per access kind
  always_comb begin
    seq_state_next = seq_state;
    prev_read_next = prev_read;
    rd_value       = '0;
    ram_we         = 1'b0;
    ram_wdata      = item_data;
    unique case (item_mode)
      pfci_pkg::MODE_READ: begin
        if (seq_state == pfci_pkg::CMD_AUTOSELECT) begin
          rd_value = id_hit ? id_value : ram_rdata;
        end else begin
          rd_value       = ram_rdata;
          seq_state_next = pfci_pkg::CMD_READ;
        end
        prev_read_next = rd_value;
      end
      pfci_pkg::MODE_WRITE: begin
        seq_state_next = write_state;
        ram_we         = cmd.exec && (prog_early || prog_late);
        ram_wdata      = ram_rdata & prog_byte;
      end
      pfci_pkg::MODE_PEEK: begin
        rd_value = ram_rdata;
      end
      pfci_pkg::MODE_LOAD: begin
        ram_we = cmd.exec;
      end
    endcase
  end

  // Latch the accepted beat
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_mode <= pfci_pkg::mode_t'(mode);
      item_addr <= address;
      item_data <= write_data;
      item_rmw  <= read_modify_write;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      read_data     <= rd_value;
      command_state <= seq_state_next;
    end
  end

  // Update configuration and sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      address_layout <= 1'b0;
      seq_state      <= pfci_pkg::CMD_READ;
      prev_read      <= '0;
    end else begin
      if (cfg_write_enable) address_layout <= cfg_write_data;
      if (cmd.exec) begin
        seq_state <= seq_state_next;
        prev_read <= prev_read_next;
      end
    end
  end

endmodule

// ===== sv/parallel_flash_command_interface_top.sv =====
// Byte-wide NOR flash bus model with the JEDEC-style command sequencer. Each input beat is one
// bus access (read, write, side-effect-free peek, or backdoor image load) and yields exactly
// one result beat carrying the byte read (zero for write and load) and the command state after
// the access. Writes walk the AA/55 unlock sequence at the magic addresses picked by
// address_layout (0: 5555/2AAA, 1: 555/2AA) into autoselect, byte program (byte ANDed into the
// array) or the erase prefix; erase is never carried out. Each beat first reads the array
// memory, whose read data is registered, then commits the sequencer update and any array
// write once the result register is free. A finished result waits in an output register
// while the next beat is taken. The array has no reset; reading a byte that was never
// loaded or programmed returns garbage. Write address_layout only while the block is idle.
module parallel_flash_command_interface_top #(
  parameter int unsigned ADDR_BITS = pfci_pkg::ADDR_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_enable,
  input  logic                            cfg_write_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      mode,
  input  logic [pfci_pkg::BUS_ADDR_W-1:0] address,
  input  logic [pfci_pkg::DATA_W-1:0]     write_data,
  input  logic                            read_modify_write,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [pfci_pkg::DATA_W-1:0]     read_data,
  output logic [3:0]                      command_state
);

  pfci_pkg::ctrl_cmd_t cmd;

  pfci_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  pfci_dp #(
    .ADDR_BITS (ADDR_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .cfg_write_enable  (cfg_write_enable),
    .cfg_write_data    (cfg_write_data),
    .mode              (mode),
    .address           (address),
    .write_data        (write_data),
    .read_modify_write (read_modify_write),
    .read_data         (read_data),
    .command_state     (command_state)
  );

endmodule
